// File: design/pgsc_pkg.sv
// Shared constants, register indexes and saturation helper for the curvature core.
package pgsc_pkg;

  // Default grid size limits
  localparam int DEF_MAX_COLS = 64;
  localparam int DEF_MAX_ROWS = 64;

  // Configuration port
  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;
  localparam logic [CFG_AW-1:0] CFG_COLS   = 3'd0;
  localparam logic [CFG_AW-1:0] CFG_ROWS   = 3'd1;
  localparam logic [CFG_AW-1:0] CFG_BIN_X  = 3'd2;
  localparam logic [CFG_AW-1:0] CFG_BIN_Y  = 3'd3;
  localparam logic [CFG_AW-1:0] CFG_FRAMES = 3'd4;
  localparam logic [CFG_AW-1:0] CFG_SIGN   = 3'd5;

  // Register reset values
  localparam logic [6:0]  RST_COUNT  = 7'd64;
  localparam logic [31:0] RST_BIN    = 32'h0001_0000;
  localparam logic [15:0] RST_FRAMES = 16'd1;
  localparam logic [1:0]  RST_SIGN   = 2'b01;

  // Stream widths
  localparam int IN_DW  = 48;
  localparam int OUT_DW = 64;

  // Q16.16 one
  localparam logic signed [31:0] QONE = 32'sh0001_0000;

  // Last iteration index of the shared divide / square-root unit
  localparam logic [5:0] DIV_LAST  = 6'd47;
  localparam logic [5:0] SQRT_LAST = 6'd23;

  // Saturate a wide signed value to 32 bits
  function automatic logic signed [31:0] sat32(input logic signed [49:0] v);
    if (v > 50'sd2147483647) begin
      return 32'sh7FFF_FFFF;
    end else if (v < -50'sd2147483648) begin
      return 32'sh8000_0000;
    end else begin
      return v[31:0];
    end
  endfunction

endpackage

// File: design/periodic_grid_surface_curvature_core.sv
// Curvature core: periodic height grid store, sequencer and shared arithmetic unit.
// Loads and out-of-range queries are taken in the idle state. A query reaches out_tvalid
// through 18 divides of 48 one-bit steps and a 24-step root on one shared unit, or through
// the gradient divides only with a zero bin width. One query at a time: in_tready returns
// once the result is in the output register, so a new query also waits on out_tready.
// rst_n (synchronous, active low) clears control and config registers, not the height store.
module periodic_grid_surface_curvature_core #(
  parameter int MAX_COLS = pgsc_pkg::DEF_MAX_COLS,
  parameter int MAX_ROWS = pgsc_pkg::DEF_MAX_ROWS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [pgsc_pkg::CFG_AW-1:0]   cfg_addr,
  input  logic [pgsc_pkg::CFG_DW-1:0]   cfg_wdata,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [pgsc_pkg::IN_DW-1:0]    in_tdata,   // col[5:0], row[11:6], height_sum[43:12]
  input  logic [0:0]                    in_tuser,   // mode
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [pgsc_pkg::OUT_DW-1:0]   out_tdata,  // gaussian[31:0], mean[63:32]
  output logic [0:0]                    out_tuser   // degenerate
);
  import pgsc_pkg::*;

  localparam int CW    = $clog2(MAX_COLS);
  localparam int RW    = $clog2(MAX_ROWS);
  localparam int DEPTH = MAX_COLS * MAX_ROWS;
  localparam int AW    = $clog2(DEPTH);

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_RDA  = 9'b000000010,
    S_RDB  = 9'b000000100,
    S_RDC  = 9'b000001000,
    S_DIV  = 9'b000010000,
    S_SQRT = 9'b000100000,
    S_EXEC = 9'b001000000,
    S_MULW = 9'b010000000,
    S_OUT  = 9'b100000000
  } state_t;

  typedef enum logic [2:0] {OP_ADD, OP_DIV, OP_MUL, OP_SQRT, OP_END} op_t;

  // Truncating half of a difference
  function automatic logic signed [31:0] half_diff(input logic signed [31:0] x,
                                                   input logic signed [31:0] y);
    logic signed [32:0] d;
    d = {x[31], x} - {y[31], y};
    d = d + {32'b0, d[32]};
    return d[32:1];
  endfunction

  // Config registers
  logic [6:0]  cols_r, rows_r;
  logic [31:0] bx_r, by_r;
  logic [15:0] fr_r;
  logic [1:0]  sign_r;

  // Control
  state_t      state_r, state_nxt;
  logic [2:0]  g_r, g_nxt;
  logic [4:0]  step_r, step_nxt;
  logic        grad_ph_r, grad_ph_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [63:0] out_data_r;
  logic        out_user_r;

  // Neighbor coordinates
  logic [CW-1:0] c0_r, cp1_r, cm1_r, cp2_r, cm2_r;
  logic [RW-1:0] r0_r, rp1_r, rm1_r, rp2_r, rm2_r;

  // Datapath values
  logic signed [31:0] grad_r [8];
  logic signed [31:0] hn_r, gxx_r, gyy_r, gxy_r;
  logic signed [31:0] a_r, b_r, sxx_r, syy_r, sxy_r, a2_r, b2_r;
  logic signed [31:0] w_r, ea_r, eb_r, t1_r, t2_r, t3_r, nk_r, nh_r, k_r, h_r;
  logic               degen_r;
  logic signed [63:0] mul_p_r;

  // Shared iterative unit
  logic [47:0] it_q_r;
  logic [32:0] it_rem_r;
  logic [23:0] it_root_r;
  logic [32:0] it_den_r;
  logic        it_neg_r;
  logic [5:0]  it_cnt_r;

  // Height store
  logic [31:0]   mem [DEPTH];
  logic [31:0]   mem_q_r;
  logic [AW-1:0] raddr, waddr;
  logic          mem_we;

  // Input fields
  logic [5:0]  in_col, in_row;
  logic [31:0] in_hsum;
  logic        in_mode;
  assign in_col  = in_tdata[5:0];
  assign in_row  = in_tdata[11:6];
  assign in_hsum = in_tdata[43:12];
  assign in_mode = in_tuser[0];

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  logic acc;
  assign acc = in_tvalid && in_tready;

  // Effective counts, sign and frame divisor
  logic [31:0] nc_full, nr_full;
  logic [15:0] fr_eff;
  logic        s_zero, s_neg, zero_bin;
  always_comb begin
    if (cols_r < 7'd3) nc_full = 32'd3;
    else if (32'(cols_r) > 32'(MAX_COLS)) nc_full = 32'(MAX_COLS);
    else nc_full = 32'(cols_r);
    if (rows_r < 7'd3) nr_full = 32'd3;
    else if (32'(rows_r) > 32'(MAX_ROWS)) nr_full = 32'(MAX_ROWS);
    else nr_full = 32'(rows_r);
  end
  assign fr_eff   = (fr_r == 16'd0) ? 16'd1 : fr_r;
  assign s_zero   = (sign_r == 2'b00);
  assign s_neg    = sign_r[1];
  assign zero_bin = (bx_r == 32'd0) || (by_r == 32'd0);

  logic q_ok, ld_ok;
  assign q_ok  = (32'(in_col) < nc_full) && (32'(in_row) < nr_full);
  assign ld_ok = (32'(in_col) < 32'(MAX_COLS)) && (32'(in_row) < 32'(MAX_ROWS));

  // Wrapped neighbors of the query cell
  logic [CW-1:0] wc0, wcp1, wcm1, wcp2, wcm2, nc_m1;
  logic [RW-1:0] wr0, wrp1, wrm1, wrp2, wrm2, nr_m1;
  always_comb begin
    nc_m1 = CW'(nc_full - 32'd1);
    nr_m1 = RW'(nr_full - 32'd1);
    wc0   = CW'(in_col);
    wcp1  = (wc0 == nc_m1) ? '0 : wc0 + 1'b1;
    wcp2  = (wcp1 == nc_m1) ? '0 : wcp1 + 1'b1;
    wcm1  = (wc0 == '0) ? nc_m1 : wc0 - 1'b1;
    wcm2  = (wcm1 == '0) ? nc_m1 : wcm1 - 1'b1;
    wr0   = RW'(in_row);
    wrp1  = (wr0 == nr_m1) ? '0 : wr0 + 1'b1;
    wrp2  = (wrp1 == nr_m1) ? '0 : wrp1 + 1'b1;
    wrm1  = (wr0 == '0) ? nr_m1 : wr0 - 1'b1;
    wrm2  = (wrm1 == '0) ? nr_m1 : wrm1 - 1'b1;
  end

  // Read address: positive-side (n) and negative-side (p) cells of each gradient
  logic [CW-1:0] ncc, pcc, rd_cc;
  logic [RW-1:0] nrr, prr, rd_rr;
  always_comb begin
    case (g_r)
      3'd0: begin ncc = cp1_r; nrr = r0_r;  pcc = cm1_r; prr = r0_r;  end
      3'd1: begin ncc = c0_r;  nrr = rp1_r; pcc = c0_r;  prr = rm1_r; end
      3'd2: begin ncc = cp2_r; nrr = r0_r;  pcc = c0_r;  prr = r0_r;  end
      3'd3: begin ncc = c0_r;  nrr = r0_r;  pcc = cm2_r; prr = r0_r;  end
      3'd4: begin ncc = c0_r;  nrr = rp2_r; pcc = c0_r;  prr = r0_r;  end
      3'd5: begin ncc = c0_r;  nrr = r0_r;  pcc = c0_r;  prr = rm2_r; end
      3'd6: begin ncc = cp1_r; nrr = rp1_r; pcc = cm1_r; prr = rp1_r; end
      default: begin ncc = cp1_r; nrr = rm1_r; pcc = cm1_r; prr = rm1_r; end
    endcase
    rd_cc = (state_r == S_RDB) ? pcc : ncc;
    rd_rr = (state_r == S_RDB) ? prr : nrr;
  end
  assign raddr  = AW'(rd_rr) * AW'(MAX_COLS) + AW'(rd_cc);
  assign waddr  = AW'(RW'(in_row)) * AW'(MAX_COLS) + AW'(CW'(in_col));
  assign mem_we = acc && !in_mode && ld_ok;

  // Height store, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[waddr] <= in_hsum;
    end
    mem_q_r <= mem[raddr];
  end

  // Micro-program decode
  op_t                op;
  logic signed [31:0] sel_a, sel_b;
  logic [32:0]        op_den;
  always_comb begin
    op     = OP_END;
    sel_a  = '0;
    sel_b  = '0;
    op_den = '0;
    case (step_r)
      5'd0:  op = OP_ADD;
      5'd1:  begin op = OP_DIV; sel_a = grad_r[0]; op_den = {1'b0, bx_r}; end
      5'd2:  begin op = OP_DIV; sel_a = grad_r[1]; op_den = {1'b0, by_r}; end
      5'd3:  begin op = OP_DIV; sel_a = gxx_r;     op_den = {1'b0, bx_r}; end
      5'd4:  begin op = OP_DIV; sel_a = sxx_r;     op_den = {1'b0, bx_r}; end
      5'd5:  begin op = OP_DIV; sel_a = gyy_r;     op_den = {1'b0, by_r}; end
      5'd6:  begin op = OP_DIV; sel_a = syy_r;     op_den = {1'b0, by_r}; end
      5'd7:  begin op = OP_DIV; sel_a = gxy_r;     op_den = {1'b0, bx_r}; end
      5'd8:  begin op = OP_DIV; sel_a = sxy_r;     op_den = {1'b0, by_r}; end
      5'd9:  begin op = OP_MUL; sel_a = a_r;   sel_b = a_r;   end
      5'd10: begin op = OP_MUL; sel_a = b_r;   sel_b = b_r;   end
      5'd11: op = OP_ADD;
      5'd12: begin op = OP_MUL; sel_a = sxx_r; sel_b = syy_r; end
      5'd13: begin op = OP_MUL; sel_a = sxy_r; sel_b = sxy_r; end
      5'd14: op = OP_ADD;
      5'd15: begin op = OP_MUL; sel_a = ea_r;  sel_b = syy_r; end
      5'd16: begin op = OP_MUL; sel_a = eb_r;  sel_b = sxx_r; end
      5'd17: begin op = OP_MUL; sel_a = a_r;   sel_b = b_r;   end
      5'd18: begin op = OP_MUL; sel_a = t3_r;  sel_b = sxy_r; end
      5'd19: op = OP_ADD;
      5'd20: op = OP_SQRT;
      5'd21: begin op = OP_MUL; sel_a = w_r;   sel_b = t3_r;  end
      5'd22: begin op = OP_MUL; sel_a = w_r;   sel_b = w_r;   end
      5'd23: begin op = OP_DIV; sel_a = nk_r;  op_den = {1'b0, t2_r}; end
      5'd24: begin op = OP_DIV; sel_a = nh_r;  op_den = {t1_r, 1'b0}; end
      default: op = OP_END;
    endcase
  end

  // Divider operands: gradient or Q16.16 quotient
  logic signed [32:0] gdiff, gnum;
  logic signed [48:0] dnum, dneg_num;
  logic [32:0]        dden;
  logic               dneg;
  always_comb begin
    gdiff = {hn_r[31], hn_r} - {mem_q_r[31], mem_q_r};
    if (s_zero) gnum = '0;
    else if (s_neg) gnum = -gdiff;
    else gnum = gdiff;
    if (state_r == S_RDC) begin
      dnum = 49'(gnum);
      dden = {16'b0, fr_eff, 1'b0};
    end else begin
      dnum = {sel_a[31], sel_a, 16'b0};
      dden = op_den;
    end
    dneg     = dnum[48];
    dneg_num = -dnum;
  end

  // Shared compare / subtract step
  logic [33:0] ux, uy;
  logic [34:0] usub;
  logic        uge;
  logic [32:0] rem_next;
  logic [47:0] q_next;
  logic [23:0] root_next;
  always_comb begin
    if (state_r == S_SQRT) begin
      ux = {6'b0, it_rem_r[25:0], it_q_r[47:46]};
      uy = {8'b0, it_root_r, 2'b01};
    end else begin
      ux = {it_rem_r, it_q_r[47]};
      uy = {1'b0, it_den_r};
    end
    usub      = {1'b0, ux} - {1'b0, uy};
    uge       = !usub[34];
    rem_next  = uge ? usub[32:0] : ux[32:0];
    q_next    = {it_q_r[46:0], uge};
    root_next = {it_root_r[22:0], uge};
  end

  // Writeback values
  logic signed [49:0] qs, mq;
  logic signed [63:0] madj;
  logic signed [31:0] wb_val;
  logic               wb_en;
  always_comb begin
    qs = signed'({2'b0, q_next});
    if (it_neg_r) qs = -qs;
    madj = mul_p_r + (mul_p_r[63] ? 64'sd65535 : 64'sd0);
    mq   = {{2{madj[63]}}, madj[63:16]};
    case (state_r)
      S_SQRT:  wb_val = {8'b0, root_next};
      S_MULW:  wb_val = sat32(mq);
      default: wb_val = sat32(qs);
    endcase
    wb_en = ((state_r == S_DIV || state_r == S_SQRT) && it_cnt_r == '0) ||
            (state_r == S_MULW);
  end

  logic out_load;
  assign out_load = (state_r == S_OUT) && (!out_valid_r || out_tready);

  // Sequencer
  always_comb begin
    state_nxt   = state_r;
    g_nxt       = g_r;
    step_nxt    = step_r;
    grad_ph_nxt = grad_ph_r;
    case (state_r)
      S_IDLE: begin
        if (acc && in_mode && q_ok) begin
          state_nxt   = S_RDA;
          g_nxt       = '0;
          grad_ph_nxt = 1'b1;
        end
      end
      S_RDA: state_nxt = S_RDB;
      S_RDB: state_nxt = S_RDC;
      S_RDC: state_nxt = S_DIV;
      S_DIV: begin
        if (it_cnt_r == '0) begin
          if (grad_ph_r) begin
            if (g_r == 3'd7) begin
              grad_ph_nxt = 1'b0;
              step_nxt    = '0;
              state_nxt   = S_EXEC;
            end else begin
              g_nxt     = g_r + 3'd1;
              state_nxt = S_RDA;
            end
          end else begin
            step_nxt  = step_r + 5'd1;
            state_nxt = S_EXEC;
          end
        end
      end
      S_SQRT: begin
        if (it_cnt_r == '0) begin
          step_nxt  = step_r + 5'd1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        case (op)
          OP_ADD: begin
            if (step_r == 5'd0 && zero_bin) state_nxt = S_OUT;
            else step_nxt = step_r + 5'd1;
          end
          OP_DIV:  state_nxt = S_DIV;
          OP_MUL:  state_nxt = S_MULW;
          OP_SQRT: state_nxt = S_SQRT;
          default: state_nxt = S_OUT;
        endcase
      end
      S_MULW: begin
        step_nxt  = step_r + 5'd1;
        state_nxt = S_EXEC;
      end
      S_OUT: begin
        if (out_load) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
    out_valid_nxt = out_load ? 1'b1 : (out_valid_r && !out_tready);
  end

  // Control registers and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      g_r         <= '0;
      step_r      <= '0;
      grad_ph_r   <= 1'b0;
      out_valid_r <= 1'b0;
      cols_r      <= RST_COUNT;
      rows_r      <= RST_COUNT;
      bx_r        <= RST_BIN;
      by_r        <= RST_BIN;
      fr_r        <= RST_FRAMES;
      sign_r      <= RST_SIGN;
    end else begin
      state_r     <= state_nxt;
      g_r         <= g_nxt;
      step_r      <= step_nxt;
      grad_ph_r   <= grad_ph_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_addr)
          CFG_COLS:   cols_r <= cfg_wdata[6:0];
          CFG_ROWS:   rows_r <= cfg_wdata[6:0];
          CFG_BIN_X:  bx_r   <= cfg_wdata;
          CFG_BIN_Y:  by_r   <= cfg_wdata;
          CFG_FRAMES: fr_r   <= cfg_wdata[15:0];
          CFG_SIGN:   sign_r <= cfg_wdata[1:0];
          default: ;
        endcase
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    // Capture query cell and its wrapped neighbors
    if (acc) begin
      c0_r <= wc0;  cp1_r <= wcp1; cm1_r <= wcm1; cp2_r <= wcp2; cm2_r <= wcm2;
      r0_r <= wr0;  rp1_r <= wrp1; rm1_r <= wrm1; rp2_r <= wrp2; rm2_r <= wrm2;
    end

    if (state_r == S_RDB) hn_r <= mem_q_r;

    // Start a divide
    if (state_r == S_RDC || (state_r == S_EXEC && op == OP_DIV)) begin
      it_q_r   <= dneg ? dneg_num[47:0] : dnum[47:0];
      it_rem_r <= '0;
      it_den_r <= dden;
      it_neg_r <= dneg;
      it_cnt_r <= DIV_LAST;
    end

    // Start a square root of w << 16
    if (state_r == S_EXEC && op == OP_SQRT) begin
      it_q_r    <= {w_r, 16'b0};
      it_rem_r  <= '0;
      it_root_r <= '0;
      it_cnt_r  <= SQRT_LAST;
    end

    // Iterate
    if (state_r == S_DIV) begin
      it_rem_r <= rem_next;
      it_q_r   <= q_next;
      it_cnt_r <= it_cnt_r - 6'd1;
    end
    if (state_r == S_SQRT) begin
      it_rem_r  <= rem_next;
      it_q_r    <= {it_q_r[45:0], 2'b00};
      it_root_r <= root_next;
      it_cnt_r  <= it_cnt_r - 6'd1;
    end

    if (state_r == S_EXEC && op == OP_MUL) mul_p_r <= sel_a * sel_b;

    // Add steps
    if (state_r == S_EXEC && op == OP_ADD) begin
      case (step_r)
        5'd0: begin
          gxx_r <= half_diff(grad_r[2], grad_r[3]);
          gyy_r <= half_diff(grad_r[4], grad_r[5]);
          gxy_r <= half_diff(grad_r[6], grad_r[7]);
          if (zero_bin) begin
            k_r     <= '0;
            h_r     <= '0;
            degen_r <= (bx_r == 32'd0 && by_r == 32'd0) ||
                       (bx_r == 32'd0 && grad_r[0] == 32'sd0) ||
                       (by_r == 32'd0 && grad_r[1] == 32'sd0);
          end else begin
            degen_r <= 1'b0;
          end
        end
        5'd11: begin
          w_r  <= sat32(50'(QONE) + 50'(a2_r) + 50'(b2_r));
          ea_r <= sat32(50'(QONE) + 50'(a2_r));
          eb_r <= sat32(50'(QONE) + 50'(b2_r));
        end
        5'd14: nk_r <= sat32(50'(t1_r) - 50'(t2_r));
        5'd19: nh_r <= sat32(50'(t1_r) + 50'(t2_r) - (50'(t3_r) <<< 1));
        default: ;
      endcase
    end

    // Result writeback
    if (wb_en) begin
      if (grad_ph_r) begin
        grad_r[g_r] <= wb_val;
      end else begin
        case (step_r)
          5'd1:  a_r   <= wb_val;
          5'd2:  b_r   <= wb_val;
          5'd3:  sxx_r <= wb_val;
          5'd4:  sxx_r <= wb_val;
          5'd5:  syy_r <= wb_val;
          5'd6:  syy_r <= wb_val;
          5'd7:  sxy_r <= wb_val;
          5'd8:  sxy_r <= wb_val;
          5'd9:  a2_r  <= wb_val;
          5'd10: b2_r  <= wb_val;
          5'd12: t1_r  <= wb_val;
          5'd13: t2_r  <= wb_val;
          5'd15: t1_r  <= wb_val;
          5'd16: t2_r  <= wb_val;
          5'd17: t3_r  <= wb_val;
          5'd18: t3_r  <= wb_val;
          5'd20: t3_r  <= wb_val;
          5'd21: t1_r  <= wb_val;
          5'd22: t2_r  <= wb_val;
          5'd23: k_r   <= wb_val;
          5'd24: h_r   <= wb_val;
          default: ;
        endcase
      end
    end

    // Output register
    if (out_load) begin
      out_data_r <= {h_r, k_r};
      out_user_r <= degen_r;
    end
  end

endmodule

// File: design/pgsc_checker.sv
// Port-level checker for the curvature core and its bind statement.
module pgsc_props (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_tvalid,
  input logic                        in_tready,
  input logic [0:0]                  in_tuser,
  input logic                        out_tvalid,
  input logic                        out_tready,
  input logic [pgsc_pkg::OUT_DW-1:0] out_tdata,
  input logic [0:0]                  out_tuser
);
  import pgsc_pkg::*;

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // Degenerate results carry zero curvatures
  a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tdata == '0)
    else $error("degenerate result with nonzero curvature");

  // Reset drops the result valid
  a_reset_clear: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("out_tvalid high after reset");

  // A load transaction leaves the block ready
  a_load_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && !in_tuser[0] |=> in_tready)
    else $error("load transaction blocked input");

endmodule

bind periodic_grid_surface_curvature_core pgsc_props u_pgsc_props (.*);

// File: test/pgsc_checker.sv
// Checker for the curvature core: mirrors registers and the height grid, predicts and compares.
module pgsc_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [31:0] cfg_wdata,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [47:0] in_tdata,
  input  logic [0:0]  in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [63:0] out_tdata,
  input  logic [0:0]  out_tuser,
  output int          fail_count,
  output int          pending,
  output int          queries_seen,
  output int          degen_seen
);
  timeunit 1ns;
  timeprecision 1ps;
  import pgsc_pkg::*;

  localparam longint Q1 = 65536;

  typedef struct packed {
    logic [31:0] gauss;
    logic [31:0] mean;
    logic        degen;
  } curv_t;

  // Mirrored configuration and height grid
  logic [6:0]  m_cols, m_rows;
  logic [31:0] m_bin_x, m_bin_y;
  logic [15:0] m_frames;
  logic [1:0]  m_sign;
  int          height_grid [DEF_MAX_COLS*DEF_MAX_ROWS];
  curv_t       curv_expected [$];
  int          pushed_n;

  function automatic longint clip32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint qmul(longint a, longint b);
    return clip32((a * b) / Q1);
  endfunction

  function automatic longint qdiv(longint a, longint b);
    return clip32((a * Q1) / b);
  endfunction

  // Bitwise integer root of x in Q16.16
  function automatic longint qroot(longint x);
    logic [63:0] v, acc, b;
    v = 64'(x) << 16;
    acc = 0;
    b = 64'd1 << 46;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= acc + b) begin
        v = v - (acc + b);
        acc = (acc >> 1) + b;
      end else begin
        acc = acc >> 1;
      end
      b = b >> 2;
    end
    return longint'(acc);
  endfunction

  function automatic int clamp_dim(logic [6:0] v);
    if (v < 3) return 3;
    if (v > 64) return 64;
    return int'(v);
  endfunction

  function automatic longint height_at(int c, int r);
    return longint'(height_grid[r*DEF_MAX_COLS + c]);
  endfunction

  function automatic longint slope(longint hn, longint hp);
    longint s, fr;
    s = (m_sign == 2'd0) ? 0 : ((m_sign == 2'd1) ? 1 : -1);
    fr = (m_frames == 0) ? 1 : longint'(m_frames);
    return (s * (hn - hp)) / (2 * fr);
  endfunction

  function automatic longint slope_x(int c, int r, int nc);
    return slope(height_at((c + 1) % nc, r), height_at((c + nc - 1) % nc, r));
  endfunction

  function automatic longint slope_y(int c, int r, int nr);
    return slope(height_at(c, (r + 1) % nr), height_at(c, (r + nr - 1) % nr));
  endfunction

  // Curvature at one cell from the mirrored state
  function automatic curv_t predict_curvature(int c, int r);
    int nc, nr;
    longint gx, gy, gxx, gyy, gxy, bx, by, a, b, sxx, syy, sxy, a2, b2, w, ea, eb;
    longint nk, nh, w32, kk, hh;
    curv_t res;
    nc = clamp_dim(m_cols);
    nr = clamp_dim(m_rows);
    bx = longint'(m_bin_x);
    by = longint'(m_bin_y);
    kk = 0;
    hh = 0;
    res.degen = 1'b0;
    gx = slope_x(c, r, nc);
    gy = slope_y(c, r, nr);
    gxx = (slope_x((c + 1) % nc, r, nc) - slope_x((c + nc - 1) % nc, r, nc)) / 2;
    gyy = (slope_y(c, (r + 1) % nr, nr) - slope_y(c, (r + nr - 1) % nr, nr)) / 2;
    gxy = (slope_x(c, (r + 1) % nr, nc) - slope_x(c, (r + nr - 1) % nr, nc)) / 2;
    if (bx == 0 || by == 0) begin
      res.degen = (bx == 0 && by == 0) || (bx == 0 && gx == 0) || (by == 0 && gy == 0);
    end else begin
      a = qdiv(gx, bx);
      b = qdiv(gy, by);
      sxx = qdiv(qdiv(gxx, bx), bx);
      syy = qdiv(qdiv(gyy, by), by);
      sxy = qdiv(qdiv(gxy, bx), by);
      a2 = qmul(a, a);
      b2 = qmul(b, b);
      w = clip32(Q1 + a2 + b2);
      ea = clip32(Q1 + a2);
      eb = clip32(Q1 + b2);
      nk = clip32(qmul(sxx, syy) - qmul(sxy, sxy));
      nh = clip32(qmul(ea, syy) + qmul(eb, sxx) - 2 * qmul(qmul(a, b), sxy));
      w32 = qmul(w, qroot(w));
      kk = qdiv(nk, qmul(w, w));
      hh = qdiv(nh, 2 * w32);
    end
    res.gauss = kk[31:0];
    res.mean = hh[31:0];
    return res;
  endfunction

  // Predictions still waiting for their result
  assign pending = pushed_n - queries_seen;

  // Watch configuration and input transactions
  always @(posedge clk) begin
    if (!rst_n) begin
      m_cols <= RST_COUNT;
      m_rows <= RST_COUNT;
      m_bin_x <= RST_BIN;
      m_bin_y <= RST_BIN;
      m_frames <= RST_FRAMES;
      m_sign <= RST_SIGN;
      pushed_n <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          CFG_COLS:   m_cols <= cfg_wdata[6:0];
          CFG_ROWS:   m_rows <= cfg_wdata[6:0];
          CFG_BIN_X:  m_bin_x <= cfg_wdata;
          CFG_BIN_Y:  m_bin_y <= cfg_wdata;
          CFG_FRAMES: m_frames <= cfg_wdata[15:0];
          CFG_SIGN:   m_sign <= cfg_wdata[1:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        if (in_tuser[0] == 1'b0) begin
          height_grid[int'(in_tdata[11:6])*DEF_MAX_COLS + int'(in_tdata[5:0])] =
            int'(in_tdata[43:12]);
        end else if (in_tdata[5:0] < clamp_dim(m_cols) && in_tdata[11:6] < clamp_dim(m_rows)) begin
          curv_expected.push_back(predict_curvature(int'(in_tdata[5:0]), int'(in_tdata[11:6])));
          pushed_n <= pushed_n + 1;
        end
      end
    end
  end

  // Compare each result transaction with the oldest prediction
  always @(posedge clk) begin
    curv_t want;
    int errs;
    errs = 0;
    if (!rst_n) begin
      fail_count <= 0;
      queries_seen <= 0;
      degen_seen <= 0;
    end else if (out_tvalid && out_tready) begin
      if (curv_expected.size() == 0) begin
        $error("unexpected result transaction: %h / %b", out_tdata, out_tuser);
        errs = 1;
      end else begin
        want = curv_expected.pop_front();
        queries_seen <= queries_seen + 1;
        if (want.degen) degen_seen <= degen_seen + 1;
        if (out_tdata[31:0] !== want.gauss) begin
          $error("gaussian_curvature: expected %h, got %h", want.gauss, out_tdata[31:0]);
          errs = errs + 1;
        end
        if (out_tdata[63:32] !== want.mean) begin
          $error("mean_curvature: expected %h, got %h", want.mean, out_tdata[63:32]);
          errs = errs + 1;
        end
        if (out_tuser[0] !== want.degen) begin
          $error("degenerate: expected %b, got %b", want.degen, out_tuser[0]);
          errs = errs + 1;
        end
      end
      fail_count <= fail_count + errs;
    end
  end

endmodule

// File: test/tb_top.sv
// Testbench top for the curvature core: stimulus, receiver stalls and verdict.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import pgsc_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [2:0]  cfg_addr;
  logic [31:0] cfg_wdata;
  logic        in_tvalid;
  logic        in_tready;
  logic [47:0] in_tdata;   // col[5:0], row[11:6], height_sum[43:12]
  logic [0:0]  in_tuser;   // mode
  logic        out_tvalid;
  logic        out_tready;
  logic [63:0] out_tdata;  // gaussian[31:0], mean[63:32]
  logic [0:0]  out_tuser;  // degenerate

  int fail_count, pending, queries_seen, degen_seen;
  int send_idle_pct, recv_stall_pct;
  int hold_seq, hold_seen, hold_left;
  int grid_cols, grid_rows;
  int items_sent;

  periodic_grid_surface_curvature_core uut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser)
  );

  pgsc_checker chk (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .fail_count(fail_count), .pending(pending),
    .queries_seen(queries_seen), .degen_seen(degen_seen)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Receiver: random stalls, plus a long hold-off on request
  initial begin
    out_tready = 1'b0;
    hold_seen = 0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_seq != hold_seen) begin
        hold_seen = hold_seq;
        hold_left = 4000;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Run limit
  initial begin
    #100ms;
    $display("RESULT: ERROR");
    $finish;
  end

  // One input transaction; valid stays high into the next call
  task automatic send_item(bit mode, int col, int row, logic [31:0] hsum);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= mode;
    in_tdata <= {4'b0, hsum, 6'(row), 6'(col)};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    items_sent++;
  endtask

  task automatic go_idle();
    in_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  // Sender stops until every prediction has been matched, then lets the core settle
  task automatic drain();
    go_idle();
    while (pending != 0) @(posedge clk);
    repeat (1000) @(posedge clk);
  endtask

  task automatic reg_write(logic [2:0] idx, logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  function automatic int clamp_dim(logic [6:0] v);
    if (v < 3) return 3;
    if (v > 64) return 64;
    return int'(v);
  endfunction

  task automatic set_regs(logic [6:0] cols, logic [6:0] rows, logic [31:0] bx,
                          logic [31:0] by, logic [15:0] frames, logic [1:0] sgn);
    reg_write(CFG_COLS, 32'(cols));
    reg_write(CFG_ROWS, 32'(rows));
    reg_write(CFG_BIN_X, bx);
    reg_write(CFG_BIN_Y, by);
    reg_write(CFG_FRAMES, 32'(frames));
    reg_write(CFG_SIGN, 32'(sgn));
    cfg_we <= 1'b0;
    @(posedge clk);
    grid_cols = clamp_dim(cols);
    grid_rows = clamp_dim(rows);
  endtask

  // Mostly moderate heights, sometimes any 32-bit value
  function automatic logic [31:0] rand_height();
    if ($urandom_range(99) < 80) return 32'($urandom_range(0, 1 << 19)) - 32'(1 << 18);
    return $urandom;
  endfunction

  // Random mix of loads and queries, idling pattern changes every 40 items
  task automatic random_phase(int count);
    int k, sel;
    for (k = 0; k < count; k++) begin
      sel = (k / 40) % 4;
      send_idle_pct  = (sel == 1) ? 62 : ((sel == 3) ? 29 : 0);
      recv_stall_pct = (sel == 2) ? 62 : ((sel == 3) ? 29 : 0);
      if ($urandom_range(99) < 70) begin
        send_item(1'b0, $urandom_range(63), $urandom_range(63), rand_height());
      end else if ($urandom_range(99) < 10) begin
        send_item(1'b1, $urandom_range(63), $urandom_range(63), $urandom);
      end else begin
        send_item(1'b1, $urandom_range(grid_cols - 1), $urandom_range(grid_rows - 1), $urandom);
      end
    end
    drain();
  endtask

  initial begin
    int c, r;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_addr = '0;
    cfg_wdata = '0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_seq = 0;
    items_sent = 0;
    grid_cols = 64;
    grid_rows = 64;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Fill every cell that the grid sizes below can reach: rows 0-9 and columns 0-2
    for (r = 0; r < 10; r++)
      for (c = 0; c < 64; c++)
        send_item(1'b0, c, r, rand_height());
    for (r = 10; r < 64; r++)
      for (c = 0; c < 3; c++)
        send_item(1'b0, c, r, rand_height());
    drain();
    set_regs(7'd64, 7'd10, 32'h0001_0000, 32'h0001_0000, 16'd1, 2'b01);

    // Directed: height extremes around the corners, wrap-around queries
    send_item(1'b0, 1, 0, 32'h7FFF_FFFF);
    send_item(1'b0, 63, 0, 32'h8000_0000);
    send_item(1'b0, 0, 1, 32'h8000_0000);
    send_item(1'b0, 0, 9, 32'h7FFF_FFFF);
    send_item(1'b1, 0, 0, 32'hFFFF_FFFF);
    send_item(1'b1, 63, 9, 32'h0);
    send_item(1'b1, 1, 1, 32'h0);
    send_item(1'b1, 62, 0, 32'h0);
    send_item(1'b0, 63, 9, 32'h0000_0000);
    send_item(1'b1, 0, 9, 32'h0);

    // Long receiver hold-off while queries keep coming
    hold_seq++;
    for (c = 0; c < 6; c++) send_item(1'b1, $urandom_range(63), $urandom_range(9), 32'h0);
    drain();

    // Small grid, smallest bins, largest frame count, negative sign
    set_regs(7'd3, 7'd3, 32'd1, 32'd1, 16'hFFFF, 2'b11);
    send_item(1'b1, 0, 0, 32'h0);
    send_item(1'b1, 2, 2, 32'h0);
    send_item(1'b1, 3, 0, 32'h0);
    send_item(1'b1, 0, 63, 32'h0);
    random_phase(160);

    // Counts below and above range, zero x bin, zero frames, zero sign
    set_regs(7'd0, 7'd127, 32'd0, 32'h0001_0000, 16'd0, 2'b00);
    send_item(1'b1, 2, 63, 32'h0);
    send_item(1'b1, 5, 5, 32'h0);
    random_phase(160);

    // Zero x bin with a live sign, so the gradient decides the flag
    set_regs(7'd64, 7'd10, 32'd0, 32'h0000_8000, 16'd1, 2'b01);
    random_phase(160);

    // Largest bins, sign code -2
    set_regs(7'd64, 7'd10, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'd7, 2'b10);
    send_item(1'b1, 63, 9, 32'h0);
    send_item(1'b1, 0, 10, 32'h0);
    random_phase(160);

    // Both bins zero
    set_regs(7'd20, 7'd10, 32'd0, 32'd0, 16'd3, 2'b01);
    random_phase(160);

    // Back to a unit x bin, with a random y bin, random counts and frames
    set_regs(7'($urandom_range(3, 64)), 7'($urandom_range(3, 10)),
             32'h0001_0000, 32'($urandom_range(1 << 12, 1 << 18)),
             16'($urandom_range(1, 8)), 2'b01);
    random_phase(160);

    go_idle();
    while (pending != 0) @(posedge clk);
    repeat (1000) @(posedge clk);
    $display("Sent %0d input transactions over seven register settings;", items_sent);
    $display("checked %0d curvature results, %0d of them degenerate.", queries_seen, degen_seen);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
